/* rtl/ctud_pkg.sv */
// Shared types and constants for the contour U-turn edge detector.
// Used by every module of the block; depends on nothing else.
package ctud_pkg;

  // Coordinate width is fixed by the point format.
  localparam int COORD_BITS = 12;
  localparam int CFG_DIM_W  = 13;
  localparam int MARGIN_W   = 8;

  // Datapath widths, all derived from the coordinate width.
  localparam int DIFF_W = COORD_BITS + 1;          // signed vector component
  localparam int SQ_W   = 2 * DIFF_W;              // signed component product
  localparam int DOT_W  = 2 * COORD_BITS + 3;      // signed dot product
  localparam int NORM_W = 2 * COORD_BITS + 1;      // squared length
  localparam int A_W    = NORM_W + 14;             // multiplicand (8281 * |v1|^2)
  localparam int B_W    = NORM_W + 7;              // multiplier (100 * dot)
  localparam int P_W    = A_W + B_W;               // full product
  localparam int MCNT_W = $clog2(B_W + 1);
  localparam int EDGE_W = ((COORD_BITS > CFG_DIM_W) ? COORD_BITS : CFG_DIM_W) + 1;

  // cos > 0.91 as (100*dot)^2 > 8281*|v1|^2*|v2|^2
  localparam int unsigned COS_SCALE = 100;
  localparam int unsigned COS_BOUND = 8281;

  localparam logic [CFG_DIM_W-1:0] COLS_RESET   = 13'd640;
  localparam logic [CFG_DIM_W-1:0] ROWS_RESET   = 13'd480;
  localparam logic [MARGIN_W-1:0]  MARGIN_RESET = 8'd10;

  typedef enum logic [1:0] {
    CFG_COLS   = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_MARGIN = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  last_point;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] break_x;
    logic [COORD_BITS-1:0] break_y;
    logic                  run_last;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  // Which neighborhood is judged: the middle point of the window, the closing
  // point, or point 0 wrapped around to the start.
  typedef enum logic [1:0] {
    J_MID  = 2'd0,
    J_END  = 2'd1,
    J_WRAP = 2'd2
  } judge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_MSTART,
    ST_MUL,
    ST_DECIDE,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic   capture;
    judge_t jsel;
    logic   prep1;
    logic   prep2;
    logic   prep3;
    logic   mul_start;
    logic   record;
    logic   commit;
  } ctud_cmd_t;

  typedef struct packed {
    logic [2:0] jen;
    logic       wk_full;
    logic       wk_empty;
    logic       qual;
    logic       mul_busy;
    logic       ob_busy;
  } ctud_sts_t;

endpackage

/* rtl/ctud_mul.sv */
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on ctud_pkg for operand and product widths.
module ctud_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [ctud_pkg::A_W-1:0] a,
  input  logic [ctud_pkg::B_W-1:0] b,
  output logic                   busy,
  output logic [ctud_pkg::P_W-1:0] prod
);
  import ctud_pkg::*;

  logic [P_W-1:0]    acc;
  logic [P_W-1:0]    a_sh;
  logic [B_W-1:0]    b_sh;
  logic [MCNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= MCNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - MCNT_W'(1);
      if (cnt == MCNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= P_W'(a);
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) acc <= acc + a_sh;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

  assign prod = acc;

endmodule

/* rtl/ctud_datapath.sv */
// Datapath: config registers, contour window, angle test, result buffers.
// Depends on ctud_pkg and ctud_mul; driven by ctud_ctrl commands.
module ctud_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  ctud_pkg::ctud_cmd_t     cmd,
  output ctud_pkg::ctud_sts_t     sts,
  input  ctud_pkg::in_item_t      in_item,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [12:0]             cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ctud_pkg::out_item_t     out_item
);
  import ctud_pkg::*;

  logic [CFG_DIM_W-1:0] cols, rows;
  logic [MARGIN_W-1:0]  margin;

  point_t     first_pt, second_pt, older_pt, newer_pt;
  logic [1:0] seen;

  point_t     cur_pt;
  logic       cur_last;
  logic [1:0] cur_seen;

  point_t prev_pt, ctr_pt, nxt_pt, j_pt;
  logic signed [DIFF_W-1:0] dx1, dy1, dx2, dy2;
  logic signed [SQ_W-1:0]   p_xx, p_yy, s_x1, s_y1, s_x2, s_y2;
  logic signed [DOT_W-1:0]  dot;
  logic [NORM_W-1:0]        n1, n2;
  logic                     near, qual;
  logic [B_W-1:0]           d_val;
  logic [A_W-1:0]           m_val;
  logic                     busy_l, busy_r;
  logic [P_W-1:0]           prod_l, prod_r;
  logic                     greater;

  point_t     wk_slot [2];
  logic [1:0] wk_count;
  point_t     ob_slot [2];
  logic [1:0] ob_count;
  logic       ob_head;

  logic [EDGE_W-1:0] xe, ye, ce, re, me;
  logic              near_now;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cols   <= COLS_RESET;
      rows   <= ROWS_RESET;
      margin <= MARGIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLS:   cols   <= cfg_data;
        CFG_ROWS:   rows   <= cfg_data;
        CFG_MARGIN: margin <= cfg_data[MARGIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // Hold the accepted point until its judgments are done
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_pt.x <= in_item.point_x;
      cur_pt.y <= in_item.point_y;
      cur_last <= in_item.last_point;
      cur_seen <= seen;
    end
  end

  // Window state advances once the item is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pt  <= '0;
      second_pt <= '0;
      older_pt  <= '0;
      newer_pt  <= '0;
      seen      <= '0;
    end else if (cmd.commit) begin
      if (cur_last) begin
        seen <= '0;
      end else begin
        if (cur_seen == 2'd0) first_pt  <= cur_pt;
        if (cur_seen == 2'd1) second_pt <= cur_pt;
        older_pt <= newer_pt;
        newer_pt <= cur_pt;
        if (cur_seen != 2'd3) seen <= cur_seen + 2'd1;
      end
    end
  end

  assign sts.jen[J_MID]  = cur_seen[1];
  assign sts.jen[J_END]  = cur_last && (cur_seen != 2'd0);
  assign sts.jen[J_WRAP] = cur_last && (cur_seen != 2'd0);

  always_comb begin
    case (cmd.jsel)
      J_MID: begin
        prev_pt = older_pt;
        ctr_pt  = newer_pt;
        nxt_pt  = cur_pt;
      end
      J_END: begin
        prev_pt = newer_pt;
        ctr_pt  = cur_pt;
        nxt_pt  = first_pt;
      end
      default: begin
        prev_pt = cur_pt;
        ctr_pt  = first_pt;
        nxt_pt  = (cur_seen == 2'd1) ? cur_pt : second_pt;
      end
    endcase
  end

  assign dx1 = DIFF_W'(prev_pt.x) - DIFF_W'(ctr_pt.x);
  assign dy1 = DIFF_W'(prev_pt.y) - DIFF_W'(ctr_pt.y);
  assign dx2 = DIFF_W'(nxt_pt.x) - DIFF_W'(ctr_pt.x);
  assign dy2 = DIFF_W'(nxt_pt.y) - DIFF_W'(ctr_pt.y);

  // Stage 1: component products
  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      p_xx <= dx1 * dx2;
      p_yy <= dy1 * dy2;
      s_x1 <= dx1 * dx1;
      s_y1 <= dy1 * dy1;
      s_x2 <= dx2 * dx2;
      s_y2 <= dy2 * dy2;
      j_pt <= ctr_pt;
    end
  end

  // Edge proximity of the judged point
  assign xe = EDGE_W'(j_pt.x);
  assign ye = EDGE_W'(j_pt.y);
  assign ce = EDGE_W'(cols);
  assign re = EDGE_W'(rows);
  assign me = EDGE_W'(margin);
  assign near_now = (xe <= me) || (ye <= me) ||
                    ((ce >= xe) && (ce <= xe + me)) ||
                    ((re >= ye) && (re <= ye + me));

  // Stage 2: dot product, squared lengths
  always_ff @(posedge clk) begin
    if (cmd.prep2) begin
      dot  <= DOT_W'(p_xx) + DOT_W'(p_yy);
      n1   <= NORM_W'(s_x1[2*COORD_BITS-1:0]) + NORM_W'(s_y1[2*COORD_BITS-1:0]);
      n2   <= NORM_W'(s_x2[2*COORD_BITS-1:0]) + NORM_W'(s_y2[2*COORD_BITS-1:0]);
      near <= near_now;
    end
  end

  // Stage 3: qualify, scale by the cosine constants
  always_ff @(posedge clk) begin
    if (cmd.prep3) begin
      qual  <= (n1 != '0) && (n2 != '0) && !dot[DOT_W-1] && (dot != '0) && near;
      d_val <= B_W'(dot[NORM_W-1:0]) * B_W'(COS_SCALE);
      m_val <= A_W'(n1) * A_W'(COS_BOUND);
    end
  end

  ctud_mul u_mul_l (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (A_W'(d_val)),
    .b     (d_val),
    .busy  (busy_l),
    .prod  (prod_l)
  );

  ctud_mul u_mul_r (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (m_val),
    .b     (B_W'(n2)),
    .busy  (busy_r),
    .prod  (prod_r)
  );

  assign greater = prod_l > prod_r;

  // Working results of the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      wk_count <= '0;
    end else if (cmd.capture) begin
      wk_count <= '0;
    end else if (cmd.record && greater && (wk_count != 2'd2)) begin
      wk_count <= wk_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.record && greater && (wk_count != 2'd2)) wk_slot[wk_count[0]] <= j_pt;
  end

  // Output buffer drains while the next item is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_count <= '0;
      ob_head  <= 1'b0;
    end else if (cmd.commit && (wk_count != 2'd0)) begin
      ob_count <= wk_count;
      ob_head  <= 1'b0;
    end else if (out_valid && out_ready) begin
      ob_count <= ob_count - 2'd1;
      ob_head  <= ~ob_head;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (wk_count != 2'd0)) begin
      ob_slot[0] <= wk_slot[0];
      ob_slot[1] <= wk_slot[1];
    end
  end

  assign out_valid         = (ob_count != 2'd0);
  assign out_item.break_x  = ob_slot[ob_head].x;
  assign out_item.break_y  = ob_slot[ob_head].y;
  assign out_item.run_last = (ob_count == 2'd1);

  assign sts.wk_full  = (wk_count == 2'd2);
  assign sts.wk_empty = (wk_count == 2'd0);
  assign sts.qual     = qual;
  assign sts.mul_busy = busy_l || busy_r;
  assign sts.ob_busy  = out_valid;

endmodule

/* rtl/ctud_ctrl.sv */
// Controller state machine: sequences the judgments of one point.
// Depends on ctud_pkg; commands ctud_datapath.
module ctud_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctud_pkg::ctud_sts_t sts,
  output ctud_pkg::ctud_cmd_t cmd
);
  import ctud_pkg::*;

  ctl_state_t state, state_next;
  judge_t     jsel, jsel_next;
  logic       last_judge;
  judge_t     jsel_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      jsel  <= J_MID;
    end else begin
      state <= state_next;
      jsel  <= jsel_next;
    end
  end

  assign last_judge = (jsel == J_WRAP);

  always_comb begin
    case (jsel)
      J_MID:   jsel_inc = J_END;
      default: jsel_inc = J_WRAP;
    endcase
  end

  always_comb begin
    state_next    = state;
    jsel_next     = jsel;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.jsel      = jsel;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          jsel_next   = J_MID;
          state_next  = ST_PREP1;
        end
      end
      ST_PREP1: begin
        if (sts.jen[jsel] && !sts.wk_full) begin
          cmd.prep1  = 1'b1;
          state_next = ST_PREP2;
        end else if (last_judge) begin
          state_next = ST_FLUSH;
        end else begin
          jsel_next = jsel_inc;
        end
      end
      ST_PREP2: begin
        cmd.prep2  = 1'b1;
        state_next = ST_PREP3;
      end
      ST_PREP3: begin
        cmd.prep3  = 1'b1;
        state_next = ST_MSTART;
      end
      ST_MSTART: begin
        if (sts.qual) begin
          cmd.mul_start = 1'b1;
          state_next    = ST_MUL;
        end else if (last_judge) begin
          state_next = ST_FLUSH;
        end else begin
          jsel_next  = jsel_inc;
          state_next = ST_PREP1;
        end
      end
      ST_MUL: begin
        if (!sts.mul_busy) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.record = 1'b1;
        if (last_judge) begin
          state_next = ST_FLUSH;
        end else begin
          jsel_next  = jsel_inc;
          state_next = ST_PREP1;
        end
      end
      ST_FLUSH: begin
        // hold until the output buffer can take this item's results
        if (sts.wk_empty || !sts.ob_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* rtl/contour_uturn_edge_detector.sv */
// Top level of the contour U-turn edge detector.
// Depends on ctud_pkg, ctud_ctrl and ctud_datapath.
//
// Usage:
//   in channel  : one contour point per request (point_x, point_y, last_point);
//                 last_point closes the contour and triggers the wrap-around checks.
//   out channel : break points, at most two per input request; run_last marks
//                 the final break point caused by that input.
//   cfg channel : always ready; writes image_cols, image_rows or edge_margin by
//                 index. Write only while the block is idle.
// Timing: one point at a time. A point is captured, its three neighborhoods
//   are always walked in turn, and it is flushed. A neighborhood that does not
//   apply is skipped; one that fails the length, sign or edge precheck stops
//   there; one that passes goes through the angle test on the 32-step
//   bit-serial multipliers. A closing point runs up to three angle tests.
// Reset: synchronous; config returns to 640 x 480 with margin 10 and the
//   contour window empties.
// Stall: results sit in a two-entry output buffer; the next point is taken
//   and worked on meanwhile, and its results wait in flush until it drains.
module contour_uturn_edge_detector (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctud_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ctud_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);
  import ctud_pkg::*;

  ctud_cmd_t cmd;
  ctud_sts_t sts;

  // register writes never stall
  assign cfg_ready = 1'b1;

  ctud_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ctud_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

/* rtl/ctud_checker.sv */
// Port-level checks for the contour U-turn edge detector.
// Depends on ctud_pkg; bound to contour_uturn_edge_detector.
module ctud_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ctud_pkg::out_item_t out_item
);
  import ctud_pkg::*;

  // a stalled break point holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled break point changed");

  // one point in flight: no back-to-back input requests
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a point is in work");

  // the second break point of a pair follows at once
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_item.run_last |=> out_valid)
    else $error("break point pair split");

  // reset empties the output buffer
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind contour_uturn_edge_detector ctud_checker u_ctud_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* tb/sv/contour_uturn_edge_detector_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for the contour U-turn edge detector: streams closed contours,
// predicts the break points in-line and checks every result. Depends on ctud_pkg.
module contour_uturn_edge_detector_test;
  import ctud_pkg::*;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  // Long enough for the worst closing point; add room for two stalled results.
  localparam int SETTLE_CYCLES = 160;
  localparam int LIMIT_CYCLES = 400_000;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_COLS;
  logic [12:0] cfg_data = '0;

  // Set for the closing stretch: no input gaps, no output stalls.
  bit calm = 1'b0;
  int mismatches = 0;

  contour_uturn_edge_detector dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Predictor: geometry registers plus the contour window (first two points,
  // last two points, and a saturating count of points in the open contour).
  // ---------------------------------------------------------------------------
  logic [12:0] cols_cfg;
  logic [12:0] rows_cfg;
  logic [7:0]  margin_cfg;
  point_t      contour_head;
  point_t      contour_second;
  point_t      trail_older;
  point_t      trail_newer;
  logic [1:0]  trail_count;

  out_item_t expected_breaks[$];
  // Break points found for the request being predicted; at most two survive.
  out_item_t step_hits[$];

  function automatic void clear_predictor();
    cols_cfg       = COLS_RESET;
    rows_cfg       = ROWS_RESET;
    margin_cfg     = MARGIN_RESET;
    contour_head   = '0;
    contour_second = '0;
    trail_older    = '0;
    trail_newer    = '0;
    trail_count    = '0;
  endfunction

  function automatic void apply_write(logic [1:0] idx, logic [12:0] data);
    case (idx)
      CFG_COLS:   cols_cfg = data;
      CFG_ROWS:   rows_cfg = data;
      CFG_MARGIN: margin_cfg = data[7:0];
      default: ;
    endcase
  endfunction

  // Right and bottom tests only hold when the point is not past the edge.
  function automatic logic hugs_border(point_t c);
    longint m, dr, db;
    m  = longint'(margin_cfg);
    dr = longint'(cols_cfg) - longint'(c.x);
    db = longint'(rows_cfg) - longint'(c.y);
    if (longint'(c.x) <= m || longint'(c.y) <= m) return 1'b1;
    if (dr >= 0 && dr <= m) return 1'b1;
    if (db >= 0 && db <= m) return 1'b1;
    return 1'b0;
  endfunction

  // cos(angle) > 0.91 as dot > 0 and 10000*dot^2 > 8281*|v1|^2*|v2|^2, exact.
  function automatic logic is_sharp_turn(point_t prv, point_t c, point_t nxt);
    longint x1, y1, x2, y2, dot, len1, len2;
    logic [127:0] lhs, rhs;
    x1   = longint'(prv.x) - longint'(c.x);
    y1   = longint'(prv.y) - longint'(c.y);
    x2   = longint'(nxt.x) - longint'(c.x);
    y2   = longint'(nxt.y) - longint'(c.y);
    dot  = x1 * x2 + y1 * y2;
    len1 = x1 * x1 + y1 * y1;
    len2 = x2 * x2 + y2 * y2;
    if (len1 == 0 || len2 == 0 || dot <= 0) return 1'b0;
    lhs = 128'(dot) * 128'(dot) * 128'(COS_SCALE * COS_SCALE);
    rhs = 128'(len1) * 128'(len2) * 128'(COS_BOUND);
    if (lhs <= rhs) return 1'b0;
    return hugs_border(c);
  endfunction

  function automatic void judge_point(point_t prv, point_t c, point_t nxt);
    out_item_t hit;
    if (step_hits.size() >= 2 || !is_sharp_turn(prv, c, nxt)) return;
    hit.break_x  = c.x;
    hit.break_y  = c.y;
    hit.run_last = 1'b0;
    step_hits = {step_hits, hit};
  endfunction

  function automatic void predict_breaks(in_item_t it);
    point_t p;
    point_t after_head;
    p.x = it.point_x;
    p.y = it.point_y;
    step_hits.delete();
    if (trail_count >= 2) judge_point(trail_older, trail_newer, p);
    if (it.last_point) begin
      // Closing: judge the final point, then point 0 last. In a two-point
      // contour the closing point is point 0's next neighbor as well.
      if (trail_count >= 1) begin
        after_head = (trail_count == 1) ? p : contour_second;
        judge_point(trail_newer, p, contour_head);
        judge_point(p, contour_head, after_head);
      end
      trail_count = '0;
    end else begin
      if (trail_count == 0) contour_head = p;
      else if (trail_count == 1) contour_second = p;
      trail_older = trail_newer;
      trail_newer = p;
      if (trail_count != 2'd3) trail_count = trail_count + 2'd1;
    end
    if (step_hits.size() > 0) step_hits[step_hits.size() - 1].run_last = 1'b1;
    expected_breaks = {expected_breaks, step_hits};
  endfunction

  function automatic void log_mismatch(logic none_waiting, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches > 10) return;
    if (none_waiting)
      $display("mismatch: break x=%0d y=%0d last=%0b arrived with none expected",
               got.break_x, got.break_y, got.run_last);
    else
      $display("mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
               want.break_x, want.break_y, want.run_last,
               got.break_x, got.break_y, got.run_last);
  endfunction

  // Sample every channel at the edge, before any of this edge's updates land.
  // Predict before checking so a same-edge request is never missed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      clear_predictor();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) predict_breaks(in_item);
      if (out_valid && out_ready) begin
        if (expected_breaks.size() == 0) begin
          log_mismatch(1'b1, '0, out_item);
        end else begin
          want = expected_breaks.pop_front();
          if (out_item.break_x !== want.break_x || out_item.break_y !== want.break_y ||
              out_item.run_last !== want.run_last)
            log_mismatch(1'b0, want, out_item);
        end
      end
    end
  end

  // Stall the result side in random bursts; hold ready high once calm.
  initial begin
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------

  // Present one point and wait for its request to be taken. Valid stays high
  // afterwards; the caller either sends again at once or parks the input.
  task automatic send_point(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                            logic last);
    in_item_t it;
    it.point_x    = x;
    it.point_y    = y;
    it.last_point = last;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_pair(int x0, int y0, int x1, int y1);
    send_point(COORD_BITS'(x0), COORD_BITS'(y0), 1'b0);
    send_point(COORD_BITS'(x1), COORD_BITS'(y1), 1'b1);
  endtask

  // Park the input and wait until every predicted break point is out, then
  // give a point with no result time to finish before anything else happens.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    do begin
      while (expected_breaks.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (expected_breaks.size() != 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data, bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!more) cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(int cols, int rows, int margin);
    settle();
    write_reg(CFG_COLS, 13'(cols), 1'b1);
    write_reg(CFG_ROWS, 13'(rows), 1'b1);
    write_reg(CFG_MARGIN, 13'(margin), 1'b0);
  endtask

  task automatic program_random_geometry();
    int cols, rows;
    case ($urandom_range(0, 7))
      0:       cols = 4096;
      1:       cols = $urandom_range(4097, 8191);
      default: cols = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(0, 7))
      0:       rows = 4096;
      1:       rows = $urandom_range(4097, 8191);
      default: rows = $urandom_range(1, 4096);
    endcase
    program_regs(cols, rows, $urandom_range(0, 255));
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    return COORD_BITS'(v);
  endfunction

  // Point within a little more than the margin of a random image edge.
  function automatic point_t border_point();
    point_t q;
    int reach;
    reach = int'(margin_cfg) + 2;
    q.x = COORD_BITS'($urandom);
    q.y = COORD_BITS'($urandom);
    case ($urandom_range(0, 3))
      0: q.x = clamp_coord($urandom_range(0, reach));
      1: q.x = clamp_coord(int'(cols_cfg) - int'($urandom_range(0, reach)));
      2: q.y = clamp_coord($urandom_range(0, reach));
      default: q.y = clamp_coord(int'(rows_cfg) - int'($urandom_range(0, reach)));
    endcase
    return q;
  endfunction

  function automatic point_t wobble(point_t q);
    point_t r;
    r.x = clamp_coord(int'(q.x) + int'($urandom_range(0, 4)) - 2);
    r.y = clamp_coord(int'(q.y) + int'($urandom_range(0, 4)) - 2);
    return r;
  endfunction

  // One closed contour. Mostly zigzags between a border point and a far point,
  // so interior points and the wrap-around both make sharp turns; the rest are
  // scattered points and contours with repeated points.
  task automatic send_random_contour(output int len);
    point_t base, far_pt, p;
    int kind, dx, dy;
    len    = $urandom_range(1, 9);
    kind   = $urandom_range(0, 9);
    base   = border_point();
    dx     = int'($urandom_range(0, 1200)) - 600;
    dy     = int'($urandom_range(0, 1200)) - 600;
    if (dx < 60 && dx > -60 && dy < 60 && dy > -60) dx = dx + 400;
    far_pt.x = clamp_coord(int'(base.x) + dx);
    far_pt.y = clamp_coord(int'(base.y) + dy);
    for (int i = 0; i < len; i++) begin
      if (kind < 2) begin
        p.x = COORD_BITS'($urandom);
        p.y = COORD_BITS'($urandom);
      end else if (kind == 2) begin
        p = (i % 3 == 0) ? far_pt : base;
      end else begin
        p = (i % 2 == 0) ? wobble(base) : wobble(far_pt);
      end
      send_point(p.x, p.y, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset geometry is 640 x 480, margin 10. A two-point contour makes both
  // points sharp turns, so it probes the border test directly.
  task automatic test_reset_geometry();
    send_point(5, 5, 1'b1);          // lone point closes with nothing
    send_pair(5, 5, 5, 100);         // left edge, point 1 then point 0
    send_pair(640, 240, 630, 240);   // on the right edge and exactly margin away
    send_pair(629, 240, 641, 240);   // one just outside the margin band, one past the edge
    send_pair(300, 480, 300, 470);   // bottom edge and its margin
    send_pair(300, 11, 11, 300);     // one past the top and left margin
    send_pair(0, 0, COORD_MAX, COORD_MAX);
    send_pair(COORD_MAX, 0, 0, COORD_MAX);
    // Repeated point: zero-length vectors never qualify.
    send_point(7, 7, 1'b0);
    send_point(7, 7, 1'b0);
    send_point(7, 300, 1'b1);
    // Zigzag along the left edge: the closing point sees three turns at once
    // and the one at point 0 is dropped.
    send_point(1, 1, 1'b0);
    send_point(1, 400, 1'b0);
    send_point(2, 2, 1'b0);
    send_point(2, 400, 1'b1);
    // Square with a tail: no turn is sharp, the point count saturates.
    send_point(100, 100, 1'b0);
    send_point(200, 100, 1'b0);
    send_point(200, 200, 1'b0);
    send_point(100, 200, 1'b0);
    send_point(150, 150, 1'b1);
  endtask

  task automatic test_register_extremes();
    program_regs(1, 1, 0);
    send_pair(1, 1, 0, 2000);
    send_pair(2, 2000, 3, 10);
    program_regs(4096, 4096, 255);
    send_pair(COORD_MAX, 2000, 3841, 2000);
    send_pair(3840, 2000, 255, 2000);
    // Zero width and an oversized height; margin data carries high bits that
    // must be dropped.
    program_regs(0, 8191, 13'h1F00);
    send_pair(0, 500, 500, 0);
    send_pair(COORD_MAX, COORD_MAX, 1000, 1000);
    // A write to the unused index changes no register.
    settle();
    write_reg(CFG_SPARE, 13'h1ABC, 1'b0);
    send_pair(0, 500, 500, 0);
  endtask

  task automatic test_random_contours(int target);
    int sent, next_cfg, len;
    sent     = 0;
    next_cfg = 0;
    while (sent < target) begin
      if (sent >= next_cfg) begin
        program_random_geometry();
        next_cfg = next_cfg + $urandom_range(60, 110);
      end
      send_random_contour(len);
      sent = sent + len;
    end
  endtask

  // Back-to-back points with the result side always ready.
  task automatic test_unbroken_stream(int target);
    int sent, len;
    sent = 0;
    program_regs(640, 480, 10);
    calm = 1'b1;
    while (sent < target) begin
      send_random_contour(len);
      sent = sent + len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_geometry();
    test_register_extremes();
    test_random_contours(340);
    test_unbroken_stream(60);
    settle();
    if (mismatches == 0 && expected_breaks.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Drop the run if the block hangs.
  initial begin
    #(LIMIT_CYCLES * 12);
    $display("status: fail");
    $finish;
  end

endmodule
